/* design/satc_pkg.sv */
package satc_pkg;

  localparam int CmdW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD_A = 2'd0,
    CMD_ADD_B = 2'd1,
    CMD_TEST  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_AXIS,
    ST_ROT,
    ST_PROJ,
    ST_CHECK,
    ST_OUT
  } state_t;

endpackage

/* design/satc_cell.sv */
module satc_cell
  import satc_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 shift_en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out
);

  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      x_r <= x_in;
      y_r <= y_in;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;

endmodule

/* design/satc_chain.sv */
module satc_chain
  import satc_pkg::*;
#(
  parameter int CW = 16,
  parameter int N  = 16
) (
  input  logic                 clk,
  input  logic                 shift_en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output logic signed [CW-1:0] x_cell [N],
  output logic signed [CW-1:0] y_cell [N]
);

  logic signed [CW-1:0] xs [N+1];
  logic signed [CW-1:0] ys [N+1];

  assign xs[0] = x_in;
  assign ys[0] = y_in;

  for (genvar i = 0; i < N; i++) begin : g_cell
    satc_cell #(.CW(CW)) u_cell (
      .clk(clk), .shift_en(shift_en),
      .x_in(xs[i]), .y_in(ys[i]), .x_out(xs[i+1]), .y_out(ys[i+1])
    );
    assign x_cell[i] = xs[i+1];
    assign y_cell[i] = ys[i+1];
  end

endmodule

/* design/sat_convex_polygon_overlap_test_unit.sv */
// Separating-axis collision test for two convex polygons.
// Input transfers carry a command in tuser and a vertex in tdata. Commands 0 and 1
// append a vertex to polygon A or B; a vertex sent to a full store is dropped and
// remembered as an overflow. Command 2 runs the test and emits one result transfer,
// then empties both stores. Command 3 is ignored. Each polygon lives in a row of
// cells that rotates one vertex per cycle while its shift is enabled; the oldest
// cell and its neighbor give the current edge. Each axis goes through ST_AXIS to
// form the edge normal, ST_PROJ to walk both polygons vertex by vertex through the
// shared dot-product unit, ST_CHECK to drain its pipeline and compare the
// intervals, and ST_ROT to rotate the edge owner. The test stops at the first
// separating axis; if a store is empty, no axis is tested and collides reads 0.
// The result waits in the output register until taken; while it waits and while
// the test runs no new input is taken. The next input can be accepted in the
// cycle after the result transfer. Reset empties both stores and clears the
// overflow flag; vertex contents are not cleared.
module sat_convex_polygon_overlap_test_unit
  import satc_pkg::*;
#(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // vertex_x [15:0], vertex_y [31:16]
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // collides [0], vertex_overflow [1], zeros above
);

  localparam int CW = COORD_BITS;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int DW = CW + 1;
  localparam int PW = 2 * CW + 4;

  state_t state_r, state_nxt;
  logic [NW-1:0] cnt_a_r, cnt_b_r;
  logic          ovf_r;
  logic          sep_r;
  logic          col_r, ovf_out_r;
  logic          own_b_r;
  logic [NW-1:0] edge_r;
  logic [NW:0]   proj_r;
  logic signed [DW-1:0] ax_r, ay_r;

  logic signed [CW-1:0] vx, vy;
  assign vx = CW'(in_tdata[15:0]);
  assign vy = CW'(in_tdata[31:16]);
  cmd_t cmd;
  assign cmd = cmd_t'(in_tuser);

  logic acc;
  assign acc = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_LOAD);

  logic load_a, load_b;
  assign load_a = acc && cmd == CMD_ADD_A && cnt_a_r < NW'(MAX_VERTICES);
  assign load_b = acc && cmd == CMD_ADD_B && cnt_b_r < NW'(MAX_VERTICES);

  logic [NW:0] tot;
  assign tot = {1'b0, cnt_a_r} + {1'b0, cnt_b_r};

  logic proj_a, shift_a, shift_b;
  assign proj_a = proj_r < {1'b0, cnt_a_r};
  assign shift_a = load_a || (state_r == ST_ROT && !own_b_r) ||
                   (state_r == ST_PROJ && proj_a);
  assign shift_b = load_b || (state_r == ST_ROT && own_b_r) ||
                   (state_r == ST_PROJ && !proj_a);

  // A loaded vertex enters at the tail while a walk recirculates from the head.
  logic signed [CW-1:0] ah_x, ah_y, an_x, an_y, bh_x, bh_y, bn_x, bn_y;
  logic signed [CW-1:0] a_in_x, a_in_y, b_in_x, b_in_y;

  // Loads and rotations shift the whole row, so the newest vertex sits in the
  // entry cell; the rotation feeds the head back to the entry cell.
  logic signed [CW-1:0] ah_rot_x, ah_rot_y, bh_rot_x, bh_rot_y;
  assign a_in_x = load_a ? vx : ah_rot_x;
  assign a_in_y = load_a ? vy : ah_rot_y;
  assign b_in_x = load_b ? vx : bh_rot_x;
  assign b_in_y = load_b ? vy : bh_rot_y;

  logic signed [CW-1:0] ra_x [MAX_VERTICES];
  logic signed [CW-1:0] ra_y [MAX_VERTICES];
  logic signed [CW-1:0] rb_x [MAX_VERTICES];
  logic signed [CW-1:0] rb_y [MAX_VERTICES];

  satc_chain #(.CW(CW), .N(MAX_VERTICES)) u_chain_a (
    .clk(clk), .shift_en(shift_a), .x_in(a_in_x), .y_in(a_in_y),
    .x_cell(ra_x), .y_cell(ra_y));
  satc_chain #(.CW(CW), .N(MAX_VERTICES)) u_chain_b (
    .clk(clk), .shift_en(shift_b), .x_in(b_in_x), .y_in(b_in_y),
    .x_cell(rb_x), .y_cell(rb_y));

  // Valid vertices occupy cells 0 .. cnt-1, newest in cell 0, oldest (head)
  // in cell cnt-1. Rotating puts the head back in cell 0.
  logic [NW-1:0] ai, bi, ai2, bi2;
  assign ai  = (cnt_a_r == '0) ? '0 : cnt_a_r - NW'(1);
  assign bi  = (cnt_b_r == '0) ? '0 : cnt_b_r - NW'(1);
  assign ai2 = (cnt_a_r < NW'(2)) ? ai : cnt_a_r - NW'(2);
  assign bi2 = (cnt_b_r < NW'(2)) ? bi : cnt_b_r - NW'(2);
  assign ah_x = ra_x[ai[$clog2(MAX_VERTICES)-1:0]];
  assign ah_y = ra_y[ai[$clog2(MAX_VERTICES)-1:0]];
  assign an_x = ra_x[ai2[$clog2(MAX_VERTICES)-1:0]];
  assign an_y = ra_y[ai2[$clog2(MAX_VERTICES)-1:0]];
  assign bh_x = rb_x[bi[$clog2(MAX_VERTICES)-1:0]];
  assign bh_y = rb_y[bi[$clog2(MAX_VERTICES)-1:0]];
  assign bn_x = rb_x[bi2[$clog2(MAX_VERTICES)-1:0]];
  assign bn_y = rb_y[bi2[$clog2(MAX_VERTICES)-1:0]];
  assign ah_rot_x = ah_x; assign ah_rot_y = ah_y;
  assign bh_rot_x = bh_x; assign bh_rot_y = bh_y;

  // Dot-product pipeline: products registered, then sum and min/max.
  logic signed [CW-1:0] px, py;
  assign px = proj_a ? ah_x : bh_x;
  assign py = proj_a ? ah_y : bh_y;
  logic signed [CW+DW-1:0] prod_x, prod_y;
  assign prod_x = px * ax_r;
  assign prod_y = py * ay_r;
  logic signed [PW-1:0] mx_r, my_r;
  logic                 pv_r, pa_r;
  logic signed [PW-1:0] q;
  assign q = mx_r + my_r;
  logic signed [PW-1:0] lo_a_r, hi_a_r, lo_b_r, hi_b_r;
  logic                 fa_r, fb_r;

  always_ff @(posedge clk) begin
    mx_r <= PW'(prod_x);
    my_r <= PW'(prod_y);
    pa_r <= proj_a;
    if (pv_r && pa_r) begin
      if (fa_r || q < lo_a_r) lo_a_r <= q;
      if (fa_r || q > hi_a_r) hi_a_r <= q;
    end
    if (pv_r && !pa_r) begin
      if (fb_r || q < lo_b_r) lo_b_r <= q;
      if (fb_r || q > hi_b_r) hi_b_r <= q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      fa_r <= 1'b1;
      fb_r <= 1'b1;
    end else begin
      pv_r <= (state_r == ST_PROJ);
      if (state_r == ST_AXIS) begin
        fa_r <= 1'b1;
        fb_r <= 1'b1;
      end else if (pv_r) begin
        if (pa_r) fa_r <= 1'b0;
        else fb_r <= 1'b0;
      end
    end
  end

  logic [NW-1:0] own_cnt;
  assign own_cnt = own_b_r ? cnt_b_r : cnt_a_r;
  logic last_edge;
  assign last_edge = (edge_r + NW'(1) == own_cnt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (acc && cmd == CMD_TEST) begin
          if (cnt_a_r == '0 || cnt_b_r == '0) state_nxt = ST_OUT;
          else state_nxt = ST_AXIS;
        end
      end
      ST_AXIS:  state_nxt = ST_PROJ;
      ST_PROJ:  if (proj_r + 1'b1 == tot) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (pv_r) state_nxt = ST_CHECK;
        else state_nxt = ST_ROT;
      end
      ST_ROT: begin
        if (sep_r || (own_b_r && last_edge)) state_nxt = ST_OUT;
        else state_nxt = ST_AXIS;
      end
      ST_OUT:   if (out_tready) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_a_r <= '0;
      cnt_b_r <= '0;
      ovf_r   <= 1'b0;
      sep_r   <= 1'b0;
      own_b_r <= 1'b0;
      edge_r  <= '0;
      proj_r  <= '0;
      col_r   <= 1'b0;
      ovf_out_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_a) cnt_a_r <= cnt_a_r + NW'(1);
      if (load_b) cnt_b_r <= cnt_b_r + NW'(1);
      if (acc && (cmd == CMD_ADD_A || cmd == CMD_ADD_B) && !load_a && !load_b)
        ovf_r <= 1'b1;
      if (acc && cmd == CMD_TEST) begin
        sep_r   <= 1'b0;
        own_b_r <= 1'b0;
        edge_r  <= '0;
        proj_r  <= '0;
        ovf_out_r <= ovf_r;
      end
      if (state_r == ST_AXIS) proj_r <= '0;
      if (state_r == ST_PROJ) proj_r <= proj_r + 1'b1;
      if (state_r == ST_CHECK && !pv_r) begin
        if (hi_b_r < lo_a_r || hi_a_r < lo_b_r) sep_r <= 1'b1;
      end
      if (state_r == ST_ROT) begin
        // The rotation of the owner polygon is one shift: ST_ROT moves one vertex.
        if (last_edge) begin
          own_b_r <= 1'b1;
          edge_r  <= '0;
        end else begin
          edge_r <= edge_r + NW'(1);
        end
      end
      if (state_r == ST_OUT && out_tready) begin
        cnt_a_r <= '0;
        cnt_b_r <= '0;
        ovf_r   <= 1'b0;
      end
      if (state_r == ST_LOAD && acc && cmd == CMD_TEST)
        col_r <= 1'b0;
      if (state_r == ST_ROT && state_nxt == ST_OUT)
        col_r <= !sep_r;
    end
  end

  // Edge of the owner: from the head vertex to the next one in load order.
  // The head is the oldest, its successor is the second oldest, so the edge
  // vector is (next - head); the last edge wraps since rotation moved the head.
  logic signed [CW-1:0] e0x, e0y, e1x, e1y;
  assign e0x = own_b_r ? bh_x : ah_x;
  assign e0y = own_b_r ? bh_y : ah_y;
  assign e1x = own_b_r ? bn_x : an_x;
  assign e1y = own_b_r ? bn_y : an_y;

  always_ff @(posedge clk) begin
    if (state_r == ST_AXIS) begin
      ax_r <= DW'(e0y) - DW'(e1y);
      ay_r <= DW'(e1x) - DW'(e0x);
    end
  end

  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {6'b0, ovf_out_r, col_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= NW'(MAX_VERTICES) && cnt_b_r <= NW'(MAX_VERTICES))
    else $error("vertex count beyond capacity");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_LOAD |-> !in_tready)
    else $error("input taken during test");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> cnt_a_r == '0 && cnt_b_r == '0 && !ovf_r)
    else $error("stores not cleared after result");

endmodule
